### rtl/core/ltood_pkg.sv
package ltood_pkg;

    localparam int ELAPSED_BITS_DEFAULT = 16;
    localparam int SAMPLE_W             = 10;
    localparam int CODE_W               = 4;
    localparam int DELAY_W              = 16;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = CODE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_ON_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_DELAY = 2'd1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [DELAY_W-1:0]  delay_t;

    // timer flags carried between the register bank and the step logic
    typedef struct packed {
        logic trigger_level;
        logic on_timing;
        logic off_timing;
    } flags_t;

    // delay in ms ticks for each code
    function automatic delay_t delay_of(input code_t code);
        delay_t d;
        unique case (code)
            4'd0:    d = 16'd0;
            4'd1:    d = 16'd50;
            4'd2:    d = 16'd100;
            4'd3:    d = 16'd200;
            4'd4:    d = 16'd400;
            4'd5:    d = 16'd800;
            4'd6:    d = 16'd1500;
            4'd7:    d = 16'd2200;
            4'd8:    d = 16'd3000;
            4'd9:    d = 16'd4000;
            4'd10:   d = 16'd5000;
            4'd11:   d = 16'd8000;
            4'd12:   d = 16'd15000;
            4'd13:   d = 16'd25000;
            4'd14:   d = 16'd40000;
            default: d = 16'd60000;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/ltood_in_if.sv
interface ltood_in_if;
    logic               valid;
    logic               ready;
    ltood_pkg::sample_t level_sample;
    ltood_pkg::sample_t threshold_sample;

    modport source (output valid, output level_sample, output threshold_sample, input ready);
    modport sink   (input valid, input level_sample, input threshold_sample, output ready);
endinterface

### rtl/core/ltood_out_if.sv
interface ltood_out_if;
    logic valid;
    logic ready;
    logic trigger;
    logic in_off_delay;

    modport source (output valid, output trigger, output in_off_delay, input ready);
    modport sink   (input valid, input trigger, input in_off_delay, output ready);
endinterface

### rtl/core/ltood_step.sv
module ltood_step #(
    parameter int ELAPSED_BITS = ltood_pkg::ELAPSED_BITS_DEFAULT
) (
    input  ltood_pkg::sample_t      level_sample,
    input  ltood_pkg::sample_t      threshold_sample,
    input  ltood_pkg::code_t        on_code,
    input  ltood_pkg::code_t        off_code,
    input  ltood_pkg::flags_t       flags,
    input  logic [ELAPSED_BITS-1:0] on_elapsed,
    input  logic [ELAPSED_BITS-1:0] off_elapsed,
    output ltood_pkg::flags_t       flags_next,
    output logic [ELAPSED_BITS-1:0] on_elapsed_next,
    output logic [ELAPSED_BITS-1:0] off_elapsed_next
);

    localparam logic [ELAPSED_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ELAPSED_BITS-1:0] COUNT_ONE = ELAPSED_BITS'(1);

    logic [ELAPSED_BITS-1:0] on_inc;
    logic [ELAPSED_BITS-1:0] off_inc;
    logic [ELAPSED_BITS-1:0] on_delay;
    logic [ELAPSED_BITS-1:0] off_delay;

    assign on_inc    = (on_elapsed == COUNT_MAX) ? on_elapsed : on_elapsed + COUNT_ONE;
    assign off_inc   = (off_elapsed == COUNT_MAX) ? off_elapsed : off_elapsed + COUNT_ONE;
    assign on_delay  = ELAPSED_BITS'(ltood_pkg::delay_of(on_code));
    assign off_delay = ELAPSED_BITS'(ltood_pkg::delay_of(off_code));

    always_comb
    begin
        flags_next       = flags;
        on_elapsed_next  = on_elapsed;
        off_elapsed_next = off_elapsed;
        priority if (level_sample >= threshold_sample)
        begin
            flags_next.off_timing = 1'b0;
            if (!flags.on_timing)
            begin
                on_elapsed_next      = '0;
                flags_next.on_timing = 1'b1;
            end
            else
            begin
                on_elapsed_next          = on_inc;
                flags_next.trigger_level = (on_inc >= on_delay);
            end
        end
        else if (flags.trigger_level)
        begin
            if (!flags.off_timing)
            begin
                off_elapsed_next      = '0;
                flags_next.off_timing = 1'b1;
            end
            else
            begin
                off_elapsed_next         = off_inc;
                flags_next.trigger_level = !(off_inc >= off_delay);
            end
        end
        else
        begin
            flags_next       = '0;
            on_elapsed_next  = '0;
            off_elapsed_next = '0;
        end
    end

endmodule

### rtl/core/level_trigger_on_off_delay.sv
// Level trigger with on/off delay, one channel, one 1 ms tick per word.
// Path: a tick word is held in the input register, then its result in the result register
// fed by the timer step logic, from where the result word is taken.
// Throughput: one tick word per cycle while results are taken (combinational timer step).
// Reset: rst_n (async, active low) clears both stages, the timer state and both delay codes.
module level_trigger_on_off_delay #(
    parameter int ELAPSED_BITS = ltood_pkg::ELAPSED_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [ltood_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltood_pkg::CFG_DATA_W-1:0]   cfg_data,
    ltood_in_if.sink                           samples,
    ltood_out_if.source                        result
);

    // delay codes
    ltood_pkg::code_t on_code_reg;
    ltood_pkg::code_t off_code_reg;

    // input stage
    logic               s1_valid_reg;
    ltood_pkg::sample_t s1_level_reg;
    ltood_pkg::sample_t s1_thresh_reg;
    logic               s1_advance;

    // timer state
    ltood_pkg::flags_t       flags_reg;
    ltood_pkg::flags_t       flags_next;
    logic [ELAPSED_BITS-1:0] on_elapsed_reg;
    logic [ELAPSED_BITS-1:0] on_elapsed_next;
    logic [ELAPSED_BITS-1:0] off_elapsed_reg;
    logic [ELAPSED_BITS-1:0] off_elapsed_next;

    // result stage
    logic out_valid_reg;
    logic out_trigger_reg;
    logic out_off_reg;

    // Register writes must be made only while idle; the block does not enforce this (no interlock with the tick path).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_code_reg  <= '0;
            off_code_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ltood_pkg::REG_ON_DELAY:  on_code_reg  <= cfg_data;
                ltood_pkg::REG_OFF_DELAY: off_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The input stage moves on whenever the result register is free or being drained,
    // so the next tick is held off only while a result waits and is not being taken.
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign samples.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (samples.ready)
            s1_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_level_reg  <= samples.level_sample;
            s1_thresh_reg <= samples.threshold_sample;
        end
    end

    ltood_step #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_step (
        .level_sample     (s1_level_reg),
        .threshold_sample (s1_thresh_reg),
        .on_code          (on_code_reg),
        .off_code         (off_code_reg),
        .flags            (flags_reg),
        .on_elapsed       (on_elapsed_reg),
        .off_elapsed      (off_elapsed_reg),
        .flags_next       (flags_next),
        .on_elapsed_next  (on_elapsed_next),
        .off_elapsed_next (off_elapsed_next)
    );

    // Timer state and the result are committed together when a tick leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            on_elapsed_reg  <= '0;
            off_elapsed_reg <= '0;
        end
        else if (s1_advance)
        begin
            flags_reg       <= flags_next;
            on_elapsed_reg  <= on_elapsed_next;
            off_elapsed_reg <= off_elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_trigger_reg <= flags_next.trigger_level;
            out_off_reg     <= flags_next.off_timing && flags_next.trigger_level;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.trigger      = out_trigger_reg;
    assign result.in_off_delay = out_off_reg;

    // off-delay flag only ever reported alongside an active trigger
    a_off_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_off_reg || out_trigger_reg))
        else $error("in_off_delay set with trigger low");

    // a running on count means the on-delay is armed
    a_on_count_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (on_elapsed_reg != '0) |-> flags_reg.on_timing)
        else $error("on count nonzero while on-delay disarmed");

    // the trigger can only rise out of an armed on-delay
    a_rise_from_on: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_reg.trigger_level) |-> $past(flags_reg.on_timing))
        else $error("trigger rose without an armed on-delay");

    // the input is held off only when both stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled with room in the pipeline");

    // state only changes when a tick is committed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> ($stable(flags_reg) && $stable(on_elapsed_reg)))
        else $error("timer state changed without a tick");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int ELAPSED_BITS  = ltood_pkg::ELAPSED_BITS_DEFAULT;
    localparam int RX_HOLD_TICKS = 80;      // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES = 8;       // settle time, well past the pipeline depth

    // spare register indexes: writes there must be dropped by the block
    localparam logic [ltood_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ltood_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef logic [ELAPSED_BITS-1:0] elapsed_t;

    // one result word: trigger level and off-delay flag after a tick
    typedef struct packed {
        logic trigger;
        logic in_off_delay;
    } trig_word_t;

    // directed tick: samples plus a hand-read result where it is obvious
    typedef struct packed {
        ltood_pkg::sample_t lvl;
        ltood_pkg::sample_t thr;
        bit                 typed;
        logic               trig;
        logic               off;
    } tick_row_t;

    logic   clk;
    logic   rst_n = 1'b0;
    logic   cfg_wen;
    logic [ltood_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ltood_pkg::CFG_DATA_W-1:0]  cfg_data;

    ltood_in_if  samples_if ();
    ltood_out_if result_if ();

    level_trigger_on_off_delay dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .result    (result_if)
    );

    // delay in ms ticks per 4-bit code
    int unsigned delay_ms_tbl [16] = '{
        0, 50, 100, 200, 400, 800, 1500, 2200,
        3000, 4000, 5000, 8000, 15000, 25000, 40000, 60000
    };

    // predictor copy of the block's registers and timer state
    ltood_pkg::code_t on_code  = '0;
    ltood_pkg::code_t off_code = '0;
    logic     trig_q   = 1'b0;
    logic     on_armed = 1'b0;
    logic     off_armed = 1'b0;
    elapsed_t on_ms    = '0;
    elapsed_t off_ms   = '0;

    trig_word_t pending_levels [$];   // expected result words, oldest first

    int errors       = 0;
    int words_sent   = 0;
    int soak_words   = 0;
    int words_seen   = 0;
    int high_seen    = 0;
    int off_seen     = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    logic rx_hold    = 1'b0;
    event rx_hold_go;

    // hand-checked opening sequence, all at the reset codes (both delays 0)
    tick_row_t directed_rows [19] = '{
        '{10'd0,    10'd0,    1'b1, 1'b0, 1'b0},  // equal samples count as signal: arms on-delay
        '{10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0},  // code 0 fires one tick after arming
        '{10'd0,    10'd1023, 1'b1, 1'b1, 1'b1},  // drop arms off-delay, still high
        '{10'd0,    10'd1,    1'b1, 1'b0, 1'b0},  // off-delay elapsed, low
        '{10'd0,    10'd1023, 1'b1, 1'b0, 1'b0},  // low with no signal clears timers
        '{10'd1023, 10'd0,    1'b1, 1'b0, 1'b0},  // re-arm
        '{10'd1023, 10'd1022, 1'b0, 1'b1, 1'b0},
        '{10'd511,  10'd512,  1'b0, 1'b1, 1'b1},  // arm off-delay
        '{10'd512,  10'd512,  1'b0, 1'b1, 1'b0},  // signal back: off-delay dropped
        '{10'd0,    10'd1,    1'b0, 1'b1, 1'b1},
        '{10'd0,    10'd1,    1'b0, 1'b0, 1'b0},  // low, on-delay left armed
        '{10'd1,    10'd0,    1'b0, 1'b1, 1'b0},  // still-armed on-delay fires at once
        '{10'd0,    10'd1023, 1'b0, 1'b1, 1'b1},
        '{10'd0,    10'd1023, 1'b0, 1'b0, 1'b0},
        '{10'd0,    10'd1023, 1'b0, 1'b0, 1'b0},  // clear
        '{10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0},
        '{10'd682,  10'd341,  1'b0, 1'b1, 1'b0},  // alternating bit patterns
        '{10'd341,  10'd682,  1'b0, 1'b1, 1'b1},
        '{10'd341,  10'd682,  1'b0, 1'b0, 1'b0}
    };

    // ------------------------------------------------------------------
    // clock, and a hard stop should the block hang
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d result words still owed", pending_levels.size());
        $display("** level_trigger_on_off_delay: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: one tick of the timer logic, returns the result word
    // ------------------------------------------------------------------
    function automatic trig_word_t advance_trigger(input ltood_pkg::sample_t lvl,
                                                   input ltood_pkg::sample_t thr);
        trig_word_t w;
        if (lvl >= thr)
        begin
            off_armed = 1'b0;
            if (!on_armed)
            begin
                on_ms    = '0;          // arming tick leaves the trigger alone
                on_armed = 1'b1;
            end
            else
            begin
                if (on_ms != '1)
                    on_ms = on_ms + elapsed_t'(1);
                trig_q = (on_ms >= delay_ms_tbl[on_code]);
            end
        end
        else if (trig_q)
        begin
            if (!off_armed)
            begin
                off_ms    = '0;
                off_armed = 1'b1;
            end
            else
            begin
                if (off_ms != '1)
                    off_ms = off_ms + elapsed_t'(1);
                trig_q = !(off_ms >= delay_ms_tbl[off_code]);
            end
        end
        else
        begin
            trig_q    = 1'b0;
            on_armed  = 1'b0;
            off_armed = 1'b0;
            on_ms     = '0;
            off_ms    = '0;
        end
        w.trigger      = trig_q;
        w.in_off_delay = off_armed & trig_q;
        return w;
    endfunction

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("[%0t] %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // result side: check every accepted word, drive ready at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        trig_word_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            words_seen++;
            if (pending_levels.size() == 0)
                flag_error($sformatf("result word with nothing expected: trigger %0b off %0b",
                                     result_if.trigger, result_if.in_off_delay));
            else
            begin
                want = pending_levels.pop_front();
                if (result_if.trigger !== want.trigger)
                    flag_error($sformatf("word %0d trigger: expected %0b, got %0b",
                                         words_seen, want.trigger, result_if.trigger));
                if (result_if.in_off_delay !== want.in_off_delay)
                    flag_error($sformatf("word %0d in_off_delay: expected %0b, got %0b",
                                         words_seen, want.in_off_delay,
                                         result_if.in_off_delay));
                high_seen += want.trigger;
                off_seen  += want.in_off_delay;
            end
        end
        result_if.ready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // long receiver hold-off, timed here so the sender keeps offering words meanwhile
    initial
    begin
        forever
        begin
            @(rx_hold_go);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_TICKS) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------
    function automatic void pick_signal(output ltood_pkg::sample_t lvl,
                                        output ltood_pkg::sample_t thr);
        int unsigned t;
        t   = $urandom_range(0, 1023);
        thr = ltood_pkg::sample_t'(t);
        lvl = ltood_pkg::sample_t'($urandom_range(t, 1023));
    endfunction

    function automatic void pick_quiet(output ltood_pkg::sample_t lvl,
                                       output ltood_pkg::sample_t thr);
        int unsigned t;
        t   = $urandom_range(1, 1023);
        thr = ltood_pkg::sample_t'(t);
        lvl = ltood_pkg::sample_t'($urandom_range(0, t - 1));
    endfunction

    // offer one tick word; valid is left high so the next word follows back to back
    task automatic send_tick(input ltood_pkg::sample_t lvl, input ltood_pkg::sample_t thr,
                             input bit use_typed = 1'b0, input trig_word_t typed_w = '0);
        trig_word_t w;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid            <= 1'b1;
        samples_if.level_sample     <= lvl;
        samples_if.threshold_sample <= thr;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        w = advance_trigger(lvl, thr);
        pending_levels.push_back(use_typed ? typed_w : w);
        words_sent++;
    endtask

    // stop offering and wait for every owed result, plus the pipeline depth
    task automatic drain_results();
        samples_if.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ltood_pkg::CFG_INDEX_W-1:0] idx,
                             input ltood_pkg::code_t val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == ltood_pkg::REG_ON_DELAY)
            on_code = val;
        else if (idx == ltood_pkg::REG_OFF_DELAY)
            off_code = val;
        @(posedge clk);
    endtask

    // bursts of signal and silence, sized around the current delays so that
    // both timers run to completion, mixed with short blips and raw noise
    task automatic run_bursts(input int words);
        int                 sent;
        int                 kind;
        int unsigned        len;
        int unsigned        k;
        ltood_pkg::sample_t lvl;
        ltood_pkg::sample_t thr;
        sent = 0;
        while (sent < words)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                len = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                           : delay_ms_tbl[on_code] + $urandom_range(1, 8);
            else if (kind < 8)
                len = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                           : delay_ms_tbl[off_code] + $urandom_range(1, 8);
            else
                len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
            begin
                if (kind < 4)
                    pick_signal(lvl, thr);
                else if (kind < 8)
                    pick_quiet(lvl, thr);
                else
                begin
                    lvl = ltood_pkg::sample_t'($urandom_range(0, 1023));
                    thr = ltood_pkg::sample_t'($urandom_range(0, 1023));
                end
                send_tick(lvl, thr);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        int                 i;
        int                 k;
        ltood_pkg::sample_t lvl;
        ltood_pkg::sample_t thr;

        samples_if.valid            <= 1'b0;
        samples_if.level_sample     <= '0;
        samples_if.threshold_sample <= '0;
        cfg_wen                     <= 1'b0;
        cfg_index                   <= '0;
        cfg_data                    <= '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset codes; sender light, receiver heavy idling
        tx_idle_pct = 12;
        rx_idle_pct = 74;
        for (i = 0; i < $size(directed_rows); i++)
            send_tick(directed_rows[i].lvl, directed_rows[i].thr, directed_rows[i].typed,
                      trig_word_t'{directed_rows[i].trig, directed_rows[i].off});
        drain_results();

        // short on-delay, immediate off
        write_reg(ltood_pkg::REG_ON_DELAY, 4'd1);
        write_reg(ltood_pkg::REG_OFF_DELAY, 4'd0);
        run_bursts(100);
        drain_results();

        // idling swapped; sender pauses half way until all results are in
        tx_idle_pct = 74;
        rx_idle_pct = 12;
        write_reg(ltood_pkg::REG_ON_DELAY, 4'd0);
        write_reg(ltood_pkg::REG_OFF_DELAY, 4'd1);
        run_bursts(55);
        drain_results();
        run_bursts(55);
        drain_results();

        // no idling; spare indexes must not disturb the codes; long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(ltood_pkg::REG_ON_DELAY, 4'd2);
        write_reg(ltood_pkg::REG_OFF_DELAY, 4'd2);
        write_reg(REG_SPARE_2, 4'd15);
        write_reg(REG_SPARE_3, 4'd15);
        -> rx_hold_go;
        run_bursts(100);
        drain_results();

        write_reg(ltood_pkg::REG_ON_DELAY, ltood_pkg::code_t'($urandom_range(0, 3)));
        write_reg(ltood_pkg::REG_OFF_DELAY, ltood_pkg::code_t'($urandom_range(0, 3)));
        run_bursts(90);
        drain_results();

        // longest delays: neither timer can run out in a short stretch of signal
        // and silence, whatever state the previous phase left behind
        write_reg(ltood_pkg::REG_ON_DELAY, 4'd15);
        write_reg(ltood_pkg::REG_OFF_DELAY, 4'd15);
        k = words_sent;
        for (i = 0; i < 24; i++)
        begin
            pick_signal(lvl, thr);
            send_tick(lvl, thr);
        end
        for (i = 0; i < 6; i++)
        begin
            pick_quiet(lvl, thr);
            send_tick(lvl, thr);
        end
        soak_words = words_sent - k;
        drain_results();

        if (pending_levels.size() != 0)
            flag_error($sformatf("%0d result words never arrived", pending_levels.size()));

        $display("covered %0d tick words (%0d at the longest delays), %0d results checked",
                 words_sent, soak_words, words_seen);
        $display("trigger high in %0d words, off-delay pending in %0d, %0d errors",
                 high_seen, off_seen, errors);
        if (errors == 0)
            $display("** level_trigger_on_off_delay: PASSED **");
        else
            $display("** level_trigger_on_off_delay: FAILED **");
        $finish;
    end

endmodule

### level_trigger_on_off_delay.f
rtl/core/ltood_pkg.sv
rtl/core/ltood_in_if.sv
rtl/core/ltood_out_if.sv
rtl/core/ltood_step.sv
rtl/core/level_trigger_on_off_delay.sv
verif/testbench.sv
